[rtl/mtep_pkg.sv]
// Shared types for the MIDI track event parser: input and result words,
// event kind codes and the report-enable register set. No dependencies.
package mtep_pkg;

  // Event kind codes carried in a result word.
  typedef enum logic [3:0] {
    KindNoteOn    = 4'd0,
    KindNoteOff   = 4'd1,
    KindVolume    = 4'd2,
    KindPan       = 4'd3,
    KindProgram   = 4'd4,
    KindTempo     = 4'd5,
    KindTimeSig   = 4'd6,
    KindKeySig    = 4'd7,
    KindMarker    = 4'd8,
    KindEndTrack  = 4'd9,
    KindError     = 4'd10
  } kind_e;

  // Configuration register indexes.
  localparam logic [1:0] CfgVolume  = 2'd0;
  localparam logic [1:0] CfgPan     = 2'd1;
  localparam logic [1:0] CfgProgram = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } in_t;

  typedef struct packed {
    kind_e        event_kind;
    logic [3:0]   channel;
    logic [6:0]   note_number;
    logic [6:0]   event_value;
    logic [31:0]  meta_value;
    logic [27:0]  delta_ticks;
    logic [31:0]  absolute_tick;
  } out_t;

  typedef struct packed {
    logic volume_en;
    logic pan_en;
    logic program_en;
  } cfg_t;

endpackage

[rtl/midi_track_event_parser.sv]
// Top level of the MIDI track event parser: input word register, result
// register and report-enable registers. Depends on mtep_pkg and mtep_core.
//
//   channel  | signals                                  | direction
//   ---------+------------------------------------------+----------
//   in       | in_valid_i, in_stall_o, in_word_i        | byte in
//   out      | out_valid_o, out_stall_i, out_word_o     | record out
//   cfg      | cfg_valid_i, cfg_ready_o, cfg_index_i,   | reg write
//            | cfg_data_i                               |
//
// One byte is taken per cycle while in_stall_o is low. A word waits in the input
// register, where the parser decodes it against its state; any record lands in
// the result register on the edge that advances the byte. in_stall_o rises only
// while a byte waits in the input register and the result register holds a
// record that the sink is stalling.
// Reset clears all parse state and sets all three report enables.
module midi_track_event_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mtep_pkg::in_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mtep_pkg::out_t out_word_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic           cfg_data_i
);
  import mtep_pkg::*;

  in_t  in_q;
  logic in_valid_q, in_valid_d;
  out_t out_q, res;
  logic out_valid_q, res_valid;
  cfg_t cfg_q;
  logic advance, in_take;

  // Advance the held byte whenever the result register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_word_i;
    end
  end

  mtep_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Load a new record, or drop the valid once the sink takes the old one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Register writes must arrive only while idle; the block does not enforce this. Always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgVolume)  cfg_q.volume_en  <= cfg_data_i;
      if (cfg_index_i == CfgPan)     cfg_q.pan_en     <= cfg_data_i;
      if (cfg_index_i == CfgProgram) cfg_q.program_en <= cfg_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register is free");

  a_record_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid) |=> (out_valid_o && out_word_o.event_kind == $past(res.event_kind)))
    else $error("decoded record not loaded into result register");

  a_no_silent_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o.absolute_tick)))
    else $error("stalled record lost or overwritten");
`endif

endmodule

[rtl/mtep_core.sv]
// Byte-wise track parser: parse state registers and the one-byte decode step.
// Depends on mtep_pkg.
module mtep_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  mtep_pkg::in_t  item_i,
  input  mtep_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  output mtep_pkg::out_t res_o
);
  import mtep_pkg::*;

  typedef enum logic [3:0] {
    PhDeltaStart, PhDeltaMore, PhStatus, PhData1, PhData2, PhSysexLen,
    PhMetaType, PhMetaLen, PhMetaBody, PhSkip, PhError
  } phase_e;

  localparam logic [7:0] StatusSysex    = 8'hF0;
  localparam logic [7:0] StatusSysexEsc = 8'hF7;
  localparam logic [7:0] StatusMeta     = 8'hFF;
  localparam logic [3:0] HiNoteOff      = 4'h8;
  localparam logic [3:0] HiNoteOn       = 4'h9;
  localparam logic [3:0] HiCtrl         = 4'hB;
  localparam logic [3:0] HiProgram      = 4'hC;
  localparam logic [3:0] HiPressure     = 4'hD;
  localparam logic [6:0] CtrlVolume     = 7'h07;
  localparam logic [6:0] CtrlPan        = 7'h0A;
  localparam logic [7:0] MetaTextFirst  = 8'h01;
  localparam logic [7:0] MetaMarker     = 8'h06;
  localparam logic [7:0] MetaTextLast   = 8'h09;
  localparam logic [7:0] MetaChanPrefix = 8'h20;
  localparam logic [7:0] MetaPortPrefix = 8'h21;
  localparam logic [7:0] MetaEndTrack   = 8'h2F;
  localparam logic [7:0] MetaTempo      = 8'h51;
  localparam logic [7:0] MetaSmpte      = 8'h54;
  localparam logic [7:0] MetaTimeSig    = 8'h58;
  localparam logic [7:0] MetaKeySig     = 8'h59;
  localparam logic [7:0] MetaSeqSpec    = 8'h7F;

  function automatic logic meta_known(input logic [7:0] t);
    meta_known = (t >= MetaTextFirst && t <= MetaTextLast) || t == MetaChanPrefix ||
                 t == MetaPortPrefix || t == MetaEndTrack || t == MetaTempo ||
                 t == MetaSmpte || t == MetaTimeSig || t == MetaKeySig ||
                 t == MetaSeqSpec;
  endfunction

  function automatic logic [2:0] payload_need(input logic [7:0] t);
    if (t == MetaTempo)        payload_need = 3'd3;
    else if (t == MetaTimeSig) payload_need = 3'd4;
    else if (t == MetaKeySig)  payload_need = 3'd2;
    else                       payload_need = 3'd0;
  endfunction

  function automatic kind_e payload_kind(input logic [7:0] t);
    if (t == MetaTempo)        payload_kind = KindTempo;
    else if (t == MetaTimeSig) payload_kind = KindTimeSig;
    else                       payload_kind = KindKeySig;
  endfunction

  phase_e       phase_q, phase_d, cur_phase;
  logic [7:0]   rs_q, rs_d, cur_rs;
  logic [27:0]  delta_q, delta_d, cur_delta;
  logic [31:0]  tick_q, tick_d, cur_tick;
  logic [6:0]   first_q, first_d, cur_first;
  logic [7:0]   kind_q, kind_d, cur_kind;
  logic [27:0]  rem_q, rem_d, cur_rem;
  logic [31:0]  pay_q, pay_d, cur_pay;

  logic [7:0]   b;
  logic [6:0]   d7;
  logic [27:0]  delta_vlq, rem_vlq, rem_dec;
  logic [32:0]  tick_sum;
  logic [2:0]   need;
  logic [6:0]   first_inc;
  logic         do_data1, do_error;

  assign b  = item_i.data_byte;
  assign d7 = b[6:0];

  always_comb begin
    cur_phase = phase_q;
    cur_rs    = rs_q;
    cur_delta = delta_q;
    cur_tick  = tick_q;
    cur_first = first_q;
    cur_kind  = kind_q;
    cur_rem   = rem_q;
    cur_pay   = pay_q;
    if (item_i.track_start) begin
      cur_phase = PhDeltaStart;
      cur_rs    = '0;
      cur_delta = '0;
      cur_tick  = '0;
      cur_first = '0;
      cur_kind  = '0;
      cur_rem   = '0;
      cur_pay   = '0;
    end

    phase_d = cur_phase;
    rs_d    = cur_rs;
    delta_d = cur_delta;
    tick_d  = cur_tick;
    first_d = cur_first;
    kind_d  = cur_kind;
    rem_d   = cur_rem;
    pay_d   = cur_pay;

    delta_vlq = (cur_phase == PhDeltaStart) ? {21'd0, d7} : {cur_delta[20:0], d7};
    tick_sum  = {1'b0, cur_tick} + {5'd0, delta_vlq};
    rem_vlq   = {cur_rem[20:0], d7};
    rem_dec   = cur_rem - 28'd1;
    need      = payload_need(cur_kind);
    first_inc = cur_first + 7'd1;
    do_data1  = 1'b0;
    do_error  = 1'b0;

    res_valid_o         = 1'b0;
    res_o               = '0;
    res_o.delta_ticks   = cur_delta;
    res_o.absolute_tick = cur_tick;

    unique case (cur_phase)
      PhDeltaStart, PhDeltaMore: begin
        delta_d = delta_vlq;
        if (b[7]) begin
          phase_d = PhDeltaMore;
        end else begin
          tick_d  = tick_sum[32] ? '1 : tick_sum[31:0];
          phase_d = PhStatus;
        end
      end
      PhStatus: begin
        if (b[7]) begin
          if (b < StatusSysex) begin
            rs_d    = b;
            phase_d = PhData1;
          end else if (b == StatusSysex || b == StatusSysexEsc) begin
            rs_d    = '0;
            rem_d   = '0;
            phase_d = PhSysexLen;
          end else if (b == StatusMeta) begin
            rs_d    = '0;
            phase_d = PhMetaType;
          end else begin
            do_error = 1'b1;
          end
        end else if (cur_rs == '0) begin
          do_error = 1'b1;
        end else begin
          do_data1 = 1'b1;
        end
      end
      PhData1: do_data1 = 1'b1;
      PhData2: begin
        phase_d = PhDeltaStart;
        res_o.channel     = cur_rs[3:0];
        res_o.event_value = d7;
        if (cur_rs[7:4] == HiNoteOff) begin
          res_valid_o       = 1'b1;
          res_o.event_kind  = KindNoteOff;
          res_o.note_number = cur_first;
        end else if (cur_rs[7:4] == HiNoteOn) begin
          res_valid_o       = 1'b1;
          res_o.event_kind  = (d7 == '0) ? KindNoteOff : KindNoteOn;
          res_o.note_number = cur_first;
        end else if (cur_rs[7:4] == HiCtrl) begin
          if (cfg_i.volume_en && cur_first == CtrlVolume) begin
            res_valid_o      = 1'b1;
            res_o.event_kind = KindVolume;
          end else if (cfg_i.pan_en && cur_first == CtrlPan) begin
            res_valid_o      = 1'b1;
            res_o.event_kind = KindPan;
          end
        end
      end
      PhSysexLen: begin
        rem_d = rem_vlq;
        if (!b[7]) phase_d = (rem_vlq != '0) ? PhSkip : PhDeltaStart;
      end
      PhMetaType: begin
        if (!meta_known(b)) begin
          do_error = 1'b1;
        end else begin
          kind_d  = b;
          rem_d   = '0;
          pay_d   = '0;
          first_d = '0;
          phase_d = PhMetaLen;
        end
      end
      PhMetaLen: begin
        rem_d = rem_vlq;
        if (!b[7]) begin
          if (cur_kind == MetaMarker) begin
            res_valid_o      = 1'b1;
            res_o.event_kind = KindMarker;
            res_o.meta_value = {4'd0, rem_vlq};
          end else if (cur_kind == MetaEndTrack) begin
            res_valid_o      = 1'b1;
            res_o.event_kind = KindEndTrack;
          end else if (need != '0 && rem_vlq == '0) begin
            res_valid_o      = 1'b1;
            res_o.event_kind = payload_kind(cur_kind);
          end
          phase_d = (rem_vlq != '0) ? PhMetaBody : PhDeltaStart;
        end
      end
      PhMetaBody: begin
        rem_d = rem_dec;
        if (cur_first < {4'd0, need}) begin
          pay_d   = {cur_pay[23:0], b};
          first_d = first_inc;
          if (first_inc == {4'd0, need} || rem_dec == '0) begin
            res_valid_o      = 1'b1;
            res_o.event_kind = payload_kind(cur_kind);
            res_o.meta_value = {cur_pay[23:0], b};
          end
        end
        if (rem_dec == '0) phase_d = PhDeltaStart;
      end
      PhSkip: begin
        rem_d = rem_dec;
        if (rem_dec == '0) phase_d = PhDeltaStart;
      end
      PhError: ;
      default: phase_d = cur_phase;
    endcase

    // First channel data byte, shared by the status and first-data phases.
    if (do_data1) begin
      first_d = d7;
      if (cur_rs[7:4] == HiProgram) begin
        phase_d = PhDeltaStart;
        if (cfg_i.program_en) begin
          res_valid_o       = 1'b1;
          res_o.event_kind  = KindProgram;
          res_o.channel     = cur_rs[3:0];
          res_o.event_value = d7;
        end
      end else if (cur_rs[7:4] == HiPressure) begin
        phase_d = PhDeltaStart;
      end else begin
        phase_d = PhData2;
      end
    end

    // Latch the error: hold in the error phase until a track start.
    if (do_error) begin
      phase_d          = PhError;
      res_valid_o      = 1'b1;
      res_o.event_kind = KindError;
      res_o.meta_value = {24'd0, b};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhDeltaStart;
      rs_q    <= '0;
      delta_q <= '0;
      tick_q  <= '0;
      first_q <= '0;
      kind_q  <= '0;
      rem_q   <= '0;
      pay_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      rs_q    <= rs_d;
      delta_q <= delta_d;
      tick_q  <= tick_d;
      first_q <= first_d;
      kind_q  <= kind_d;
      rem_q   <= rem_d;
      pay_q   <= pay_d;
    end
  end

`ifndef ASSERT_OFF
  a_error_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhError && !item_i.track_start) |-> !res_valid_o)
    else $error("result produced while error is latched");

  a_error_enters_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_valid_o && res_o.event_kind == KindError) |=> phase_q == PhError)
    else $error("error result without error latch");

  a_meta_no_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.event_kind == KindTempo || res_o.event_kind == KindTimeSig ||
     res_o.event_kind == KindKeySig || res_o.event_kind == KindMarker ||
     res_o.event_kind == KindEndTrack)) |-> (res_o.channel == '0 && res_o.event_value == '0))
    else $error("meta result carries channel fields");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for midi_track_event_parser: streams random and
// directed track bytes, predicts every event record and checks each one.
// Depends on mtep_pkg and the RTL of the parser.
module testbench;
  import mtep_pkg::*;

  // Run limits and pacing.
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned LongHold     = 120;

  // Channel status nibbles.
  localparam logic [3:0] HiNoteOff   = 4'h8;
  localparam logic [3:0] HiNoteOn    = 4'h9;
  localparam logic [3:0] HiControl   = 4'hB;
  localparam logic [3:0] HiProgram   = 4'hC;
  localparam logic [3:0] HiChanPress = 4'hD;
  localparam logic [3:0] HiPitchBend = 4'hE;

  // System status bytes.
  localparam logic [7:0] StSysex    = 8'hF0;
  localparam logic [7:0] StTimeCode = 8'hF1;
  localparam logic [7:0] StSongPos  = 8'hF6;
  localparam logic [7:0] StEscape   = 8'hF7;
  localparam logic [7:0] StClock    = 8'hF8;
  localparam logic [7:0] StSense    = 8'hFE;
  localparam logic [7:0] StMeta     = 8'hFF;

  // Controller numbers that get reported.
  localparam logic [7:0] CcVolume = 8'h07;
  localparam logic [7:0] CcPan    = 8'h0A;

  // Meta event types.
  localparam logic [7:0] MetaTextFirst   = 8'h01;
  localparam logic [7:0] MetaMarker      = 8'h06;
  localparam logic [7:0] MetaTextLast    = 8'h09;
  localparam logic [7:0] MetaChanPrefix  = 8'h20;
  localparam logic [7:0] MetaPortPrefix  = 8'h21;
  localparam logic [7:0] MetaEndTrack    = 8'h2F;
  localparam logic [7:0] MetaTempo       = 8'h51;
  localparam logic [7:0] MetaSmpte       = 8'h54;
  localparam logic [7:0] MetaTimeSig     = 8'h58;
  localparam logic [7:0] MetaKeySig      = 8'h59;
  localparam logic [7:0] MetaSeqSpecific = 8'h7F;

  typedef enum logic [3:0] {
    PhDeltaStart, PhDeltaMore, PhStatus, PhData1, PhData2, PhSysexLen,
    PhMetaType, PhMetaLen, PhMetaBody, PhSkip, PhError
  } parse_phase_e;

  // Tracks the parser's decode state, predicts the record each byte causes
  // and holds the records still owed by the block.
  class midi_record_board;
    logic          vol_en, pan_en, prog_en;
    parse_phase_e  phase;
    logic [7:0]    run_status;
    logic [27:0]   delta_acc;
    logic [31:0]   abs_tick;
    logic [7:0]    held_data;
    logic [7:0]    meta_type;
    logic [27:0]   remaining;
    logic [31:0]   payload;
    bit            halted;
    out_t          due_records[$];
    int unsigned   bad_records;
    int unsigned   live_bytes;

    function new();
      vol_en      = 1'b1;
      pan_en      = 1'b1;
      prog_en     = 1'b1;
      bad_records = 0;
      live_bytes  = 0;
      clear_track();
    endfunction

    function void clear_track();
      phase      = PhDeltaStart;
      run_status = '0;
      delta_acc  = '0;
      abs_tick   = '0;
      held_data  = '0;
      meta_type  = '0;
      remaining  = '0;
      payload    = '0;
      halted     = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic val);
      case (idx)
        CfgVolume:  vol_en  = val;
        CfgPan:     pan_en  = val;
        CfgProgram: prog_en = val;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_records.size();
    endfunction

    function logic [27:0] vlq_step(logic [27:0] acc, logic [7:0] b);
      return {acc[20:0], b[6:0]};
    endfunction

    function bit meta_type_known(logic [7:0] t);
      return (t >= MetaTextFirst && t <= MetaTextLast) || t == MetaChanPrefix ||
             t == MetaPortPrefix || t == MetaEndTrack || t == MetaTempo ||
             t == MetaSmpte || t == MetaTimeSig || t == MetaKeySig ||
             t == MetaSeqSpecific;
    endfunction

    // Payload bytes that carry the value of a tempo or signature record.
    function int unsigned meta_width(logic [7:0] t);
      case (t)
        MetaTempo:   return 3;
        MetaTimeSig: return 4;
        MetaKeySig:  return 2;
        default:     return 0;
      endcase
    endfunction

    function kind_e meta_record_kind(logic [7:0] t);
      if (t == MetaTempo) return KindTempo;
      if (t == MetaTimeSig) return KindTimeSig;
      return KindKeySig;
    endfunction

    function void push_record(kind_e k, logic [3:0] ch, logic [6:0] note,
                              logic [6:0] val, logic [31:0] meta);
      out_t rec;
      rec.event_kind    = k;
      rec.channel       = ch;
      rec.note_number   = note;
      rec.event_value   = val;
      rec.meta_value    = meta;
      rec.delta_ticks   = delta_acc;
      rec.absolute_tick = abs_tick;
      due_records.push_back(rec);
    endfunction

    // Latch the error; everything after it is dropped until a track start.
    function void flag_error(logic [7:0] b);
      halted = 1'b1;
      phase  = PhError;
      push_record(KindError, 4'd0, 7'd0, 7'd0, {24'd0, b});
    endfunction

    function void take_first(logic [7:0] b);
      held_data = {1'b0, b[6:0]};
      if (run_status[7:4] == HiProgram) begin
        phase = PhDeltaStart;
        if (prog_en) push_record(KindProgram, run_status[3:0], 7'd0, b[6:0], '0);
      end else if (run_status[7:4] == HiChanPress) begin
        phase = PhDeltaStart;
      end else begin
        phase = PhData2;
      end
    endfunction

    function void take_second(logic [7:0] b);
      logic [3:0] ch;
      ch    = run_status[3:0];
      phase = PhDeltaStart;
      case (run_status[7:4])
        HiNoteOff: push_record(KindNoteOff, ch, held_data[6:0], b[6:0], '0);
        HiNoteOn: begin
          // Velocity zero reads as a release.
          push_record((b[6:0] == 0) ? KindNoteOff : KindNoteOn, ch, held_data[6:0],
                      b[6:0], '0);
        end
        HiControl: begin
          if (vol_en && held_data == CcVolume)
            push_record(KindVolume, ch, 7'd0, b[6:0], '0);
          else if (pan_en && held_data == CcPan)
            push_record(KindPan, ch, 7'd0, b[6:0], '0);
        end
        default: ;
      endcase
    endfunction

    // Advance the decode state by one accepted word.
    function void note_byte(in_t w);
      logic [7:0]  b;
      logic [32:0] sum;
      int unsigned need;
      b = w.data_byte;
      if (w.track_start) clear_track();
      if (halted) return;
      live_bytes++;
      case (phase)
        PhDeltaStart, PhDeltaMore: begin
          if (phase == PhDeltaStart) delta_acc = '0;
          delta_acc = vlq_step(delta_acc, b);
          if (b[7]) begin
            phase = PhDeltaMore;
          end else begin
            sum      = {1'b0, abs_tick} + {5'd0, delta_acc};
            abs_tick = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            phase    = PhStatus;
          end
        end
        PhStatus: begin
          if (!b[7]) begin
            // Running status only carries over channel messages.
            if (run_status == '0) flag_error(b);
            else take_first(b);
          end else if (b < StSysex) begin
            run_status = b;
            phase      = PhData1;
          end else if (b == StSysex || b == StEscape) begin
            run_status = '0;
            remaining  = '0;
            phase      = PhSysexLen;
          end else if (b == StMeta) begin
            run_status = '0;
            phase      = PhMetaType;
          end else begin
            flag_error(b);
          end
        end
        PhData1: take_first(b);
        PhData2: take_second(b);
        PhSysexLen: begin
          remaining = vlq_step(remaining, b);
          if (!b[7]) phase = (remaining != 0) ? PhSkip : PhDeltaStart;
        end
        PhMetaType: begin
          if (!meta_type_known(b)) begin
            flag_error(b);
          end else begin
            meta_type = b;
            remaining = '0;
            payload   = '0;
            held_data = '0;
            phase     = PhMetaLen;
          end
        end
        PhMetaLen: begin
          remaining = vlq_step(remaining, b);
          if (!b[7]) begin
            need = meta_width(meta_type);
            if (meta_type == MetaMarker)
              push_record(KindMarker, 4'd0, 7'd0, 7'd0, {4'd0, remaining});
            else if (meta_type == MetaEndTrack)
              push_record(KindEndTrack, 4'd0, 7'd0, 7'd0, '0);
            else if (need > 0 && remaining == 0)
              push_record(meta_record_kind(meta_type), 4'd0, 7'd0, 7'd0, '0);
            phase = (remaining != 0) ? PhMetaBody : PhDeltaStart;
          end
        end
        PhMetaBody: begin
          remaining = remaining - 1'b1;
          need      = meta_width(meta_type);
          if (held_data < need) begin
            payload = {payload[23:0], b};
            held_data++;
            if (held_data == need || remaining == 0)
              push_record(meta_record_kind(meta_type), 4'd0, 7'd0, 7'd0, payload);
          end
          if (remaining == 0) phase = PhDeltaStart;
        end
        PhSkip: begin
          remaining = remaining - 1'b1;
          if (remaining == 0) phase = PhDeltaStart;
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want_v, got_v);
        bad_records++;
      end
    endfunction

    function void check_record(out_t got);
      out_t want;
      if (due_records.size() == 0) begin
        $error("record with nothing pending: kind %0d meta 0x%0h", got.event_kind,
               got.meta_value);
        bad_records++;
        return;
      end
      want = due_records.pop_front();
      compare_field("event_kind", want.event_kind, got.event_kind);
      compare_field("channel", want.channel, got.channel);
      compare_field("note_number", want.note_number, got.note_number);
      compare_field("event_value", want.event_value, got.event_value);
      compare_field("meta_value", want.meta_value, got.meta_value);
      compare_field("delta_ticks", want.delta_ticks, got.delta_ticks);
      compare_field("absolute_tick", want.absolute_tick, got.absolute_tick);
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_t        in_word_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_t       out_word_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = CfgVolume;
  logic       cfg_data_i  = 1'b0;

  midi_record_board sb = new();

  // Pacing knobs, owned by the stimulus process.
  int unsigned src_idle_pct   = 35;
  int unsigned sink_stall_pct = 64;
  bit          hold_request   = 1'b0;

  // Long sink hold, owned by the sink process.
  int unsigned hold_left  = 0;
  bit          hold_taken = 1'b0;

  int unsigned cycle_count = 0;

  // Byte stream under construction and the generator's view of the track.
  in_t        track_bytes[$];
  bit         next_start      = 1'b0;
  bit         gen_status_live = 1'b0;
  logic [7:0] last_status     = '0;

  midi_track_event_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sink side: check every accepted record word, then pick the next stall.
  // Once asked, hold the output off for a long stretch so the input backs up.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_record(out_word_o);
    if (hold_request && !hold_taken) begin
      hold_left  = LongHold;
      hold_taken = 1'b1;
    end
    if (hold_left != 0) hold_left--;
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < sink_stall_pct);
  end

  // ---------------------------------------------------------------------
  // Stream construction
  // ---------------------------------------------------------------------

  function automatic void put_byte(logic [7:0] b);
    in_t w;
    w.data_byte = b;
    w.track_start = next_start;
    next_start = 1'b0;
    track_bytes.push_back(w);
  endfunction

  // Mark the next word as the first of a fresh track.
  function automatic void begin_track();
    next_start      = 1'b1;
    gen_status_live = 1'b0;
  endfunction

  // Encode a VLQ, padded with leading continuation groups up to groups.
  function automatic void put_vlq(logic [31:0] v, int unsigned groups);
    int unsigned n;
    logic [6:0]  grp;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    if (groups > n) n = groups;
    for (int i = n - 1; i >= 0; i--) begin
      grp = 7'(v >> (7 * i));
      put_byte({i != 0, grp});
    end
  endfunction

  function automatic void put_delta();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) put_vlq($urandom_range(127), 1);
    else if (pick < 85) put_vlq($urandom_range(16383), 1);
    else if (pick < 95) put_vlq($urandom_range(32'h0FFF_FFFF), $urandom_range(1, 4));
    else put_vlq($urandom, 5);   // over-long VLQ, top bits dropped
  endfunction

  function automatic void put_channel(logic [3:0] hi, logic [3:0] ch, logic [7:0] d1,
                                      logic [7:0] d2, bit running);
    if (!running) put_byte({hi, ch});
    put_byte(d1);
    if (hi != HiProgram && hi != HiChanPress) put_byte(d2);
    last_status     = {hi, ch};
    gen_status_live = 1'b1;
  endfunction

  function automatic void put_meta(logic [7:0] t, int unsigned len, int unsigned groups);
    put_byte(StMeta);
    put_byte(t);
    put_vlq(len, groups);
    repeat (len) put_byte(8'($urandom_range(255)));
    gen_status_live = 1'b0;
  endfunction

  function automatic void put_sysex(logic [7:0] st, int unsigned len, int unsigned groups);
    put_byte(st);
    put_vlq(len, groups);
    repeat (len) put_byte(8'($urandom_range(255)));
    gen_status_live = 1'b0;
  endfunction

  function automatic void random_channel();
    logic [3:0] hi, ch;
    logic [7:0] d1, d2;
    bit         running;
    running = gen_status_live && ($urandom_range(99) < 30);
    hi = running ? last_status[7:4] : 4'($urandom_range(HiNoteOff, HiPitchBend));
    ch = running ? last_status[3:0] : 4'($urandom_range(15));
    d1 = 8'($urandom_range(127));
    if (hi == HiControl) begin
      case ($urandom_range(2))
        0: d1 = CcVolume;
        1: d1 = CcPan;
        default: ;
      endcase
    end
    d2 = ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom_range(127));
    // A set top bit in a data slot is masked; keep it off the first byte
    // under running status, where it would read as a status.
    if (!running && $urandom_range(99) < 5) d1[7] = 1'b1;
    if ($urandom_range(99) < 5) d2[7] = 1'b1;
    put_channel(hi, ch, d1, d2, running);
  endfunction

  function automatic void random_meta();
    int unsigned pick, len;
    logic [7:0]  t;
    pick = $urandom_range(99);
    if (pick < 25) t = MetaTempo;
    else if (pick < 40) t = MetaTimeSig;
    else if (pick < 55) t = MetaKeySig;
    else if (pick < 65) t = MetaMarker;
    else if (pick < 72) t = MetaEndTrack;
    else begin
      do t = 8'($urandom_range(255)); while (!sb.meta_type_known(t));
    end
    pick = $urandom_range(99);
    if (pick < 50) len = (sb.meta_width(t) != 0) ? sb.meta_width(t) : $urandom_range(4);
    else if (pick < 96) len = $urandom_range(6);
    else len = 130;
    put_meta(t, len, ($urandom_range(9) == 0) ? 2 : 1);
  endfunction

  function automatic void random_sysex();
    int unsigned len;
    len = ($urandom_range(99) < 4) ? 130 : $urandom_range(8);
    put_sysex($urandom_range(1) ? StSysex : StEscape, len,
              ($urandom_range(9) == 0) ? 2 : 1);
  endfunction

  // Broken sequences; each one ends by restarting the track.
  function automatic void random_noise();
    logic [7:0] t;
    case ($urandom_range(4))
      0: begin
        put_delta();
        put_byte($urandom_range(1) ? 8'($urandom_range(StTimeCode, StSongPos))
                                   : 8'($urandom_range(StClock, StSense)));
        // Words after the error are dropped by the block.
        put_vlq(0, 1);
        put_channel(HiNoteOn, 4'($urandom_range(15)), 8'h40, 8'h40, 1'b0);
      end
      1: begin
        begin_track();
        put_delta();
        put_byte(8'($urandom_range(127)));   // data with no running status
      end
      2: begin
        put_delta();
        put_byte(StMeta);
        do t = 8'($urandom_range(255)); while (sb.meta_type_known(t));
        put_byte(t);
      end
      3: begin
        put_delta();                          // event cut short by a new track
        put_byte({HiNoteOn, 4'($urandom_range(15))});
      end
      default: begin
        repeat ($urandom_range(3, 6)) put_byte(8'($urandom_range(255)));
      end
    endcase
    begin_track();
  endfunction

  function automatic void random_event();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) begin_track();
    if (pick < 90) begin
      put_delta();
      pick = $urandom_range(99);
      if (pick < 60) random_channel();
      else if (pick < 88) random_meta();
      else random_sysex();
    end else begin
      random_noise();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offer one word after a random gap; hold it until it is taken.
  task automatic send_word(in_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(w);
  endtask

  task automatic send_track_bytes();
    while (track_bytes.size() != 0) send_word(track_bytes.pop_front());
  endtask

  // Drop valid and wait until every pending record has arrived and the
  // pipeline has emptied behind the last word.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(logic vol, logic pan, logic prog);
    logic [1:0] idx[3];
    logic       val[3];
    idx = '{CfgVolume, CfgPan, CfgProgram};
    val = '{vol, pan, prog};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Note extremes, running status, velocity zero, the three enabled
  // reports, a tempo and an illegal status followed by a dropped word.
  task automatic run_directed();
    begin_track();
    put_vlq(0, 1);
    put_channel(HiNoteOn, 4'hF, 8'h7F, 8'h7F, 1'b0);
    put_vlq(0, 1);
    put_channel(HiNoteOn, 4'hF, 8'h00, 8'h00, 1'b1);
    put_vlq(200, 1);
    put_channel(HiControl, 4'h5, CcVolume, 8'h40, 1'b0);
    put_vlq(0, 1);
    put_channel(HiControl, 4'h5, CcPan, 8'hFF, 1'b1);
    put_vlq(0, 1);
    put_channel(HiProgram, 4'h0, 8'h7F, 8'h00, 1'b0);
    put_vlq(0, 1);
    put_meta(MetaTempo, 3, 1);
    put_vlq(0, 1);
    put_byte(StTimeCode);
    put_byte(8'h00);
    send_track_bytes();
  endtask

  // Keep generating events until enough words have been decoded.
  task automatic random_events(int unsigned count);
    int unsigned base;
    base = sb.live_bytes;
    begin_track();
    while (sb.live_bytes - base < count) begin
      random_event();
      send_track_bytes();
    end
  endtask

  // Push the tick sum past 32 bits with maximum deltas.
  task automatic saturation_track();
    begin_track();
    for (int i = 0; i < 18; i++) begin
      put_vlq(32'h0FFF_FFFF, 4);
      put_channel(HiNoteOn, 4'h3, 8'h3C, 8'h40, i != 0);
    end
    put_vlq(0, 1);
    put_meta(MetaEndTrack, 0, 1);
    send_track_bytes();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender sparse-ish, sink mostly stalled; enables at reset value.
    run_directed();
    wait_idle();
    write_regs(1'b0, 1'b0, 1'b0);
    random_events(95);

    // Swap the idle rates.
    wait_idle();
    src_idle_pct = 64;
    sink_stall_pct <= 35;
    write_regs(1'b1, 1'b0, 1'b1);
    random_events(95);

    // Full rate both ways, with one long sink hold to back up the input.
    wait_idle();
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    write_regs(1'b0, 1'b1, 1'b0);
    hold_request <= 1'b1;
    random_events(95);

    wait_idle();
    write_regs(1'b1, 1'b1, 1'b1);
    saturation_track();
    random_events(25);

    wait_idle();
    if (sb.bad_records == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
